### rtl/wrea_pkg.sv
// Package for the weighted residual energy accumulator.
// Payload structs, queue entry type and datapath widths. No dependencies.
`timescale 1ns / 1ps

package wrea_pkg;

  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned GAIN_W       = 2 * FIELD_W;
  localparam int unsigned PROD_W       = GAIN_W + FIELD_W;
  localparam int unsigned PRIOR_SHIFT  = 26;
  localparam int unsigned SP_W         = PROD_W - PRIOR_SHIFT;
  localparam int unsigned RES_W        = SP_W + 1;
  localparam int unsigned SQ_W         = 2 * RES_W;
  localparam int unsigned WPROD_W      = SQ_W + FIELD_W;
  localparam int unsigned TERM_W       = WPROD_W - FIELD_W;
  localparam int unsigned SUM_W        = 63;
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned OCC_W        = $clog2(FRONT_STAGES + 1);
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam logic signed [FIELD_W-1:0] DIST_SCALE_RST = 16'sd4096;

  typedef struct packed {
    logic signed [FIELD_W-1:0] data_imag;
    logic signed [FIELD_W-1:0] data_real;
    logic signed [FIELD_W-1:0] prior_imag;
    logic signed [FIELD_W-1:0] prior_real;
    logic signed [FIELD_W-1:0] transfer_weight;
    logic        [FIELD_W-1:0] inverse_variance;
    logic                      last_element;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0] weighted_sum;
    logic             saturated;
  } out_item_t;

  typedef struct packed {
    logic [TERM_W-1:0] term;
    logic              last;
  } q_entry_t;

endpackage

### rtl/wrea_front.sv
// Front end: accepts beats and computes each weighted squared residual term.
// Four-stage pipeline, one multiply level per stage. Uses wrea_pkg.
`timescale 1ns / 1ps

module wrea_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic signed [15:0]           cfg_wr_data,
  input  logic                         in_fire,
  input  wrea_pkg::in_item_t           in_data,
  output logic                         push,
  output wrea_pkg::q_entry_t           push_data,
  output logic [wrea_pkg::OCC_W-1:0]   occ
);
  import wrea_pkg::*;

  logic signed [FIELD_W-1:0] dist_scale_r;

  logic                      v1_r, v2_r, v3_r, v4_r;
  logic signed [GAIN_W-1:0]  gain1_r;
  logic signed [FIELD_W-1:0] d_re1_r, d_im1_r, p_re1_r, p_im1_r;
  logic        [FIELD_W-1:0] ivar1_r, ivar2_r, ivar3_r;
  logic                      last1_r, last2_r, last3_r, last4_r;
  logic signed [FIELD_W-1:0] d_re2_r, d_im2_r;
  logic signed [SP_W-1:0]    sp_re2_r, sp_im2_r;
  logic        [SQ_W-1:0]    sq_re3_r, sq_im3_r;
  logic        [TERM_W-1:0]  term4_r;

  logic signed [GAIN_W-1:0]  gain;
  logic signed [PROD_W-1:0]  prod_re, prod_im;
  logic signed [RES_W-1:0]   res_re, res_im;
  logic signed [SQ_W-1:0]    sq_re, sq_im;
  logic        [SQ_W-1:0]    mag;
  logic        [WPROD_W-1:0] wprod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_scale_r <= DIST_SCALE_RST;
    end else if (cfg_wr_en) begin
      dist_scale_r <= cfg_wr_data;
    end
  end

  assign gain    = dist_scale_r * in_data.transfer_weight;
  assign prod_re = gain1_r * p_re1_r;
  assign prod_im = gain1_r * p_im1_r;
  assign res_re  = RES_W'(d_re2_r) - RES_W'(sp_re2_r);
  assign res_im  = RES_W'(d_im2_r) - RES_W'(sp_im2_r);
  assign sq_re   = res_re * res_re;
  assign sq_im   = res_im * res_im;
  assign mag     = sq_re3_r + sq_im3_r;
  assign wprod   = mag * ivar3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    gain1_r  <= gain;
    d_re1_r  <= in_data.data_real;
    d_im1_r  <= in_data.data_imag;
    p_re1_r  <= in_data.prior_real;
    p_im1_r  <= in_data.prior_imag;
    ivar1_r  <= in_data.inverse_variance;
    last1_r  <= in_data.last_element;
    // floor shift of the scaled prior is the arithmetic top slice
    sp_re2_r <= prod_re[PROD_W-1:PRIOR_SHIFT];
    sp_im2_r <= prod_im[PROD_W-1:PRIOR_SHIFT];
    d_re2_r  <= d_re1_r;
    d_im2_r  <= d_im1_r;
    ivar2_r  <= ivar1_r;
    last2_r  <= last1_r;
    sq_re3_r <= sq_re;
    sq_im3_r <= sq_im;
    ivar3_r  <= ivar2_r;
    last3_r  <= last2_r;
    term4_r  <= wprod[WPROD_W-1:FIELD_W];
    last4_r  <= last3_r;
  end

  assign push           = v4_r;
  assign push_data.term = term4_r;
  assign push_data.last = last4_r;
  assign occ = OCC_W'(v1_r) + OCC_W'(v2_r) + OCC_W'(v3_r) + OCC_W'(v4_r);

endmodule

### rtl/wrea_queue.sv
// Short queue of computed terms between front and back.
// Register array with head read; no overflow guard, the top holds credits. Uses wrea_pkg.
`timescale 1ns / 1ps

module wrea_queue #(
  parameter int unsigned DEPTH = wrea_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  wrea_pkg::q_entry_t             push_data,
  input  logic                           pop,
  output logic                           not_empty,
  output wrea_pkg::q_entry_t             head,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import wrea_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_entry_t             mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]     count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

### rtl/wrea_back.sv
// Back end: saturating 63-bit accumulation of queued terms and result register.
// Emits the sum and clip flag on a last term, then clears. Uses wrea_pkg.
`timescale 1ns / 1ps

module wrea_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               not_empty,
  input  wrea_pkg::q_entry_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output wrea_pkg::out_item_t out_data
);
  import wrea_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             sat_r, sat_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [SUM_W:0]   add;
  logic [SUM_W-1:0] acc;
  logic             clip;

  assign pop  = not_empty && (!head.last || !out_valid_r || out_ready);
  assign add  = {1'b0, sum_r} + (SUM_W+1)'(head.term);
  assign clip = add[SUM_W];
  assign acc  = clip ? '1 : add[SUM_W-1:0];

  always_comb begin
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (head.last) begin
        out_data_nxt.weighted_sum = acc;
        out_data_nxt.saturated    = sat_r || clip;
        out_valid_nxt             = 1'b1;
        sum_nxt                   = '0;
        sat_nxt                   = 1'b0;
      end else begin
        sum_nxt = acc;
        sat_nxt = sat_r || clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r       <= sum_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/weighted_residual_energy_accumulator.sv
// Weighted residual energy accumulator, top level.
// Instantiates wrea_front, wrea_queue and wrea_back; uses wrea_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one complex sample beat per cycle.
//   out_valid/out_ready/out_data carry one result per pass, emitted on the
//   beat marked last_element: the saturated weighted sum and the clip flag.
//   cfg_wr_en/cfg_wr_data write disturbance_scale (Q4.12) while idle;
//   it takes effect on the next beat.
// Timing:
//   One beat per cycle sustained while out_ready keeps up. The front is
//   a fixed 4-stage multiply pipeline; the back accumulator adds one
//   queued term per cycle while no last term waits on out_ready.
// Stall:
//   When out_ready is low with a result pending, the next last term waits at
//   the queue head; the front keeps running and in_ready falls once front
//   stages plus queued terms reach QUEUE_DEPTH.
// Reset:
//   rst_n low clears the sum, the clip flag, the queue and the pipeline
//   valids, and sets disturbance_scale to 1.0.
`timescale 1ns / 1ps

module weighted_residual_energy_accumulator #(
  parameter int unsigned QUEUE_DEPTH = wrea_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic signed [15:0]  cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  wrea_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wrea_pkg::out_item_t out_data
);
  import wrea_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CRED_W = ((CNT_W > OCC_W) ? CNT_W : OCC_W) + 1;

  logic               in_fire;
  logic               push, pop, not_empty;
  q_entry_t           push_data, head;
  logic [OCC_W-1:0]   occ;
  logic [CNT_W-1:0]   count;
  logic [CRED_W-1:0]  used;

  assign used     = CRED_W'(occ) + CRED_W'(count);
  assign in_ready = (used < CRED_W'(QUEUE_DEPTH));
  assign in_fire  = in_valid && in_ready;

  wrea_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .in_data     (in_data),
    .push        (push),
    .push_data   (push_data),
    .occ         (occ)
  );

  wrea_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head),
    .count     (count)
  );

  wrea_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### rtl/wrea_checker.sv
// Port-level checks for the weighted residual energy accumulator.
// Bound to the top level; uses wrea_pkg.
`timescale 1ns / 1ps

module wrea_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input wrea_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input wrea_pkg::out_item_t out_data
);
  import wrea_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad port state after reset");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.weighted_sum == {SUM_W{1'b1}})
    else $error("clipped result is not full scale");

endmodule

bind weighted_residual_energy_accumulator wrea_checker u_wrea_checker (.*);

### verif/weighted_residual_energy_accumulator_test.sv
// Testbench for the weighted residual energy accumulator.
// Drives sample beats and disturbance_scale writes, and checks each result beat
// against a local predictor. Depends on wrea_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module weighted_residual_energy_accumulator_test;
  import wrea_pkg::*;

  localparam int N_DIRECTED   = 14;
  localparam int N_PHASES     = 6;
  localparam int PHASE_BEATS  = 150;
  localparam int SETTLE       = 16;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      cfg_wr_en   = 1'b0;
  logic signed [FIELD_W-1:0] cfg_wr_data = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data     = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  out_item_t                 out_data;

  weighted_residual_energy_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // predictor state
  logic signed [FIELD_W-1:0] scale_now  = DIST_SCALE_RST;
  logic [SUM_W-1:0]          pass_sum   = '0;
  logic                      pass_clip  = 1'b0;
  out_item_t                 energy_due[$];

  int   bad_fields   = 0;
  int   stall_cycles = 0;
  logic hold_req     = 1'b0;
  logic calm         = 1'b0;
  out_item_t want;

  in_item_t  dir_beat [N_DIRECTED];
  logic      dir_known[N_DIRECTED];
  out_item_t dir_res  [N_DIRECTED];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] beat_energy(input in_item_t b,
                                                   input logic signed [FIELD_W-1:0] scale);
    longint gain, r_re, r_im, mag, prod;
    gain = longint'(scale) * longint'($signed(b.transfer_weight));
    r_re = longint'($signed(b.data_real)) - ((gain * longint'($signed(b.prior_real))) >>> 26);
    r_im = longint'($signed(b.data_imag)) - ((gain * longint'($signed(b.prior_imag))) >>> 26);
    mag  = r_re * r_re + r_im * r_im;
    prod = mag * longint'(b.inverse_variance);
    return SUM_W'(prod >>> 16);
  endfunction

  function automatic in_item_t mk_beat(input int di, input int dr, input int pi, input int pr,
                                       input int tw, input int iv, input bit last);
    in_item_t b;
    b.data_imag        = FIELD_W'(di);
    b.data_real        = FIELD_W'(dr);
    b.prior_imag       = FIELD_W'(pi);
    b.prior_real       = FIELD_W'(pr);
    b.transfer_weight  = FIELD_W'(tw);
    b.inverse_variance = FIELD_W'(iv);
    b.last_element     = last;
    return b;
  endfunction

  function automatic out_item_t mk_res(input logic [SUM_W-1:0] sum, input logic clip);
    out_item_t r;
    r.weighted_sum = sum;
    r.saturated    = clip;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return FIELD_W'($urandom_range(0, 64));
      default: return FIELD_W'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_beat(input bit last);
    return mk_beat(int'(rand_word()), int'(rand_word()), int'(rand_word()),
                   int'(rand_word()), int'(rand_word()), int'(rand_word()), last);
  endfunction

  // offer one beat, hold it until taken, then fold it into the predictor
  task automatic push_beat(input in_item_t b, input bit pinned, input out_item_t pinned_res);
    logic [SUM_W-1:0] term;
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    term = beat_energy(b, scale_now);
    if (term > SUM_MAX - pass_sum) begin
      pass_sum  = SUM_MAX;
      pass_clip = 1'b1;
    end else begin
      pass_sum = pass_sum + term;
    end
    if (b.last_element) begin
      energy_due.push_back(pinned ? pinned_res : mk_res(pass_sum, pass_clip));
      pass_sum  = '0;
      pass_clip = 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (energy_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(input logic signed [FIELD_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scale_now    = v;
  endtask

  // receiver
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (energy_due.size() == 0) begin
        $error("unexpected result beat: weighted_sum %0d saturated %0d",
               out_data.weighted_sum, out_data.saturated);
        bad_fields++;
      end else begin
        want = energy_due.pop_front();
        if (out_data.weighted_sum !== want.weighted_sum) begin
          $error("weighted_sum: expected %0d, actual %0d",
                 want.weighted_sum, out_data.weighted_sum);
          bad_fields++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0d, actual %0d", want.saturated, out_data.saturated);
          bad_fields++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic signed [FIELD_W-1:0] phase_scale[N_PHASES];
    int sent, plen;

    // zero beat, sub-LSB term, data extremes, zero weight, max gain,
    // floor of a negative scaled prior, a multi-beat pass, exact cancellation
    dir_beat[0]  = mk_beat(0, 0, 0, 0, 0, 0, 1);
    dir_beat[1]  = mk_beat(0, 1, 0, 0, 0, 65535, 1);
    dir_beat[2]  = mk_beat(-32768, -32768, 0, 0, 0, 65535, 1);
    dir_beat[3]  = mk_beat(32767, 32767, -32768, -32768, -32768, 0, 1);
    dir_beat[4]  = mk_beat(32767, 32767, -32768, -32768, -32768, 65535, 1);
    dir_beat[5]  = mk_beat(-32768, -32768, 32767, 32767, 32767, 65535, 1);
    dir_beat[6]  = mk_beat(-32768, -32768, 1, -1, 1, 65535, 1);
    dir_beat[7]  = mk_beat(100, -200, 300, -400, 8192, 1000, 0);
    dir_beat[8]  = mk_beat(-1, -1, -1, -1, -1, 65535, 0);
    dir_beat[9]  = mk_beat(32767, -32768, 5, 9, -16384, 32768, 0);
    dir_beat[10] = mk_beat(7, 7, -7, -7, 32767, 1, 0);
    dir_beat[11] = mk_beat(-5000, 4000, 2000, -3000, 12000, 60000, 1);
    dir_beat[12] = mk_beat(1234, -4321, 1234, -4321, 16384, 65535, 1);
    dir_beat[13] = mk_beat(12345, -321, -7, 77, -5000, 40000, 1);
    for (int i = 0; i < N_DIRECTED; i++) begin
      dir_known[i] = 1'b0;
      dir_res[i]   = '0;
    end
    dir_known[0]  = 1'b1;
    dir_known[1]  = 1'b1;
    dir_known[2]  = 1'b1;
    dir_res[2]    = mk_res(63'd2147450880, 1'b0);
    dir_known[3]  = 1'b1;
    dir_known[12] = 1'b1;

    phase_scale[0] = 16'sh7FFF;
    phase_scale[1] = 16'sh8000;
    phase_scale[2] = 16'sh0000;
    phase_scale[3] = FIELD_W'($urandom);
    phase_scale[4] = FIELD_W'($urandom);
    phase_scale[5] = DIST_SCALE_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      maybe_gap();
      push_beat(dir_beat[i], dir_known[i], dir_res[i]);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain_pipe();
      write_scale(phase_scale[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == N_PHASES - 1) calm = 1'b1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if (p == 1) plen = $urandom_range(1, 3);
        else if ($urandom_range(0, 9) == 0) plen = $urandom_range(20, 60);
        else plen = $urandom_range(1, 6);
        for (int k = 0; k < plen; k++) begin
          maybe_gap();
          push_beat(rand_beat(k == plen - 1), 1'b0, '0);
          sent++;
        end
      end
    end

    drain_pipe();
    repeat (20) @(posedge clk);
    if (bad_fields == 0 && energy_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
